[src/xwrb_pkg.sv]
// ----------------------------------------------------------------------------
// xwrb_pkg
// Shared types and constants for the extended RAM window register block:
// register offsets, stub reset bytes, controller state and command structs.
// ----------------------------------------------------------------------------
package xwrb_pkg;

    // Extended RAM geometry.
    localparam int RAM_ADDR_W = 16;

    // Register offsets inside the 32-byte window.
    localparam logic [4:0] OFF_RW0      = 5'h04;
    localparam logic [4:0] OFF_STEP0    = 5'h05;
    localparam logic [4:0] OFF_ADDR0_LO = 5'h06;
    localparam logic [4:0] OFF_ADDR0_HI = 5'h07;
    localparam logic [4:0] OFF_RW1      = 5'h08;
    localparam logic [4:0] OFF_STEP1    = 5'h09;
    localparam logic [4:0] OFF_ADDR1_LO = 5'h0A;
    localparam logic [4:0] OFF_ADDR1_HI = 5'h0B;
    localparam logic [4:0] OFF_STACK    = 5'h0C;

    localparam logic [15:0] WINDOW_BYTES = 16'd32;

    localparam logic [7:0] BYTE_MISS = 8'hFF;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic clr_step;   // write one zero byte of the RAM clearing pass
        logic capture;    // latch the incoming word
        logic exec;       // perform the access
        logic finish;     // take reload data, load the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;   // clearing pass is at its final address
    } dp_status_t;

    // Reset value of each window byte.
    function automatic logic [7:0] reset_byte(input logic [4:0] off);
        logic [7:0] val;
        unique case (off)
            5'h10:   val = 8'hB8;
            5'h11:   val = 8'h50;
            5'h13:   val = 8'hA9;
            5'h15:   val = 8'hA2;
            5'h17:   val = 8'h60;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

[src/xwrb_ctrl.sv]
// ----------------------------------------------------------------------------
// xwrb_ctrl
// Sequencer for the window block: RAM clearing pass after reset, then one
// bus word at a time through execute and finish, with the output handshake.
// ----------------------------------------------------------------------------
module xwrb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  xwrb_pkg::dp_status_t  status,
    output xwrb_pkg::ctrl_cmd_t   cmd
);

    xwrb_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xwrb_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            xwrb_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = xwrb_pkg::ST_IDLE;
                end
            end
            xwrb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = xwrb_pkg::ST_EXEC;
                end
            end
            xwrb_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = xwrb_pkg::ST_FINISH;
            end
            xwrb_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    // The next word may enter while this one retires.
                    cmd.finish = 1'b1;
                    in_ready   = 1'b1;
                    if (in_valid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = xwrb_pkg::ST_EXEC;
                    end
                    else
                    begin
                        state_next = xwrb_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = xwrb_pkg::ST_IDLE;
            end
        endcase
        out_valid_next = cmd.finish || (out_valid_reg && !out_ready);
    end

    assign out_valid = out_valid_reg;

endmodule

[src/xwrb_dp.sv]
// ----------------------------------------------------------------------------
// xwrb_dp
// Datapath of the window block: window register bytes, the two stepping
// access ports, the extended RAM, the byte stack memory and the result byte.
// ----------------------------------------------------------------------------
module xwrb_dp #(
    parameter int STACK_DEPTH = 512,
    parameter int WINDOW_BASE = 928
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  xwrb_pkg::ctrl_cmd_t   cmd,
    output xwrb_pkg::dp_status_t  status,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  req_type,
    input  logic [15:0]           bus_address,
    input  logic [7:0]            write_data,
    output logic [7:0]            read_data
);

    localparam int TOP_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W  = $clog2(STACK_DEPTH);
    localparam logic [TOP_W-1:0] DEPTH_T = TOP_W'(STACK_DEPTH);
    localparam logic [15:0] BASE_W = 16'(WINDOW_BASE);
    localparam int RAM_WORDS = 2 ** xwrb_pkg::RAM_ADDR_W;

    // Configuration and captured word.
    logic        enabled_reg;
    logic        write_q_reg;
    logic [15:0] addr_q_reg;
    logic [7:0]  wdata_q_reg;

    // Window bytes.
    logic [7:0] regs_reg [32];

    // Extended RAM and its read path.
    logic [7:0]  ram_mem [RAM_WORDS];
    logic [7:0]  ram_rdata_reg;
    logic [15:0] clr_cnt_reg;
    logic        byp_vld_reg;
    logic [7:0]  byp_data_reg;

    // Byte stack.
    logic [7:0]       stack_mem [STACK_DEPTH];
    logic [7:0]       stack_rdata_reg;
    logic [TOP_W-1:0] top_reg;

    // Pending prefetch / stack display reloads for the finish cycle.
    logic load_port_reg;
    logic load_sel_reg;
    logic load_stack_reg;

    logic [7:0] result_reg;
    logic [7:0] read_data_reg;

    // Decode.
    logic [15:0] rel;
    logic [4:0]  off;
    logic        hit;
    logic        is_rw, is_addr, addr_sel, rw_sel, is_stack, is_plain;
    logic [15:0] addr0, addr1, cur_addr, adv_addr, wr_addr, reload_addr;
    logic [7:0]  step;
    logic        rw_store, port_adv, addr_wr, reload;
    logic        push_ok, pop_ok, pop_show;
    logic [TOP_W-1:0] top_plus, top_minus;
    logic        ram_we, ram_re;
    logic [15:0] ram_wa;
    logic [7:0]  ram_wd;
    logic [7:0]  result_next;
    logic [7:0]  ram_data;

    always_comb
    begin
        rel      = addr_q_reg - BASE_W;
        off      = rel[4:0];
        hit      = enabled_reg && (addr_q_reg >= BASE_W) && (rel < xwrb_pkg::WINDOW_BYTES);
        is_rw    = (off == xwrb_pkg::OFF_RW0) || (off == xwrb_pkg::OFF_RW1);
        rw_sel   = (off == xwrb_pkg::OFF_RW1);
        is_addr  = (off == xwrb_pkg::OFF_ADDR0_LO) || (off == xwrb_pkg::OFF_ADDR0_HI)
                || (off == xwrb_pkg::OFF_ADDR1_LO) || (off == xwrb_pkg::OFF_ADDR1_HI);
        addr_sel = (off == xwrb_pkg::OFF_ADDR1_LO) || (off == xwrb_pkg::OFF_ADDR1_HI);
        is_stack = (off == xwrb_pkg::OFF_STACK);
        is_plain = !is_rw && !is_stack;

        addr0    = {regs_reg[xwrb_pkg::OFF_ADDR0_HI], regs_reg[xwrb_pkg::OFF_ADDR0_LO]};
        addr1    = {regs_reg[xwrb_pkg::OFF_ADDR1_HI], regs_reg[xwrb_pkg::OFF_ADDR1_LO]};
        cur_addr = rw_sel ? addr1 : addr0;
        step     = rw_sel ? regs_reg[xwrb_pkg::OFF_STEP1] : regs_reg[xwrb_pkg::OFF_STEP0];
        adv_addr = cur_addr + {{8{step[7]}}, step};

        // Address after a write to one of the address bytes.
        priority case (1'b1)
            off == xwrb_pkg::OFF_ADDR0_LO: wr_addr = {addr0[15:8], wdata_q_reg};
            off == xwrb_pkg::OFF_ADDR0_HI: wr_addr = {wdata_q_reg, addr0[7:0]};
            off == xwrb_pkg::OFF_ADDR1_LO: wr_addr = {addr1[15:8], wdata_q_reg};
            default:                       wr_addr = {wdata_q_reg, addr1[7:0]};
        endcase

        rw_store    = hit && write_q_reg && is_rw;
        port_adv    = hit && is_rw;
        addr_wr     = hit && write_q_reg && is_addr;
        reload      = port_adv || addr_wr;
        reload_addr = is_rw ? adv_addr : wr_addr;

        top_plus  = top_reg + 1'b1;
        top_minus = top_reg - 1'b1;
        push_ok   = hit && write_q_reg && is_stack && (top_reg != '0);
        pop_ok    = hit && !write_q_reg && is_stack && (top_reg < DEPTH_T);
        pop_show  = pop_ok && (top_plus < DEPTH_T);

        ram_we = cmd.clr_step || (cmd.exec && rw_store);
        ram_re = cmd.exec && reload;
        ram_wa = cmd.clr_step ? clr_cnt_reg : cur_addr;
        ram_wd = cmd.clr_step ? xwrb_pkg::BYTE_ZERO : wdata_q_reg;

        // The stack byte reads as 0 when empty, so one mux serves every read.
        if (write_q_reg)
        begin
            result_next = xwrb_pkg::BYTE_ZERO;
        end
        else if (!hit)
        begin
            result_next = xwrb_pkg::BYTE_MISS;
        end
        else
        begin
            result_next = regs_reg[off];
        end

        ram_data = byp_vld_reg ? byp_data_reg : ram_rdata_reg;
    end

    assign status.clr_last = (clr_cnt_reg == 16'hFFFF);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg    <= 1'b0;
            clr_cnt_reg    <= '0;
            top_reg        <= DEPTH_T;
            load_port_reg  <= 1'b0;
            load_sel_reg   <= 1'b0;
            load_stack_reg <= 1'b0;
            byp_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                enabled_reg <= cfg_wr_data;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.exec)
            begin
                load_port_reg  <= reload;
                load_sel_reg   <= is_rw ? rw_sel : addr_sel;
                load_stack_reg <= pop_ok;
                byp_vld_reg    <= rw_store && (cur_addr == reload_addr);
                if (push_ok)
                begin
                    top_reg <= top_minus;
                end
                else if (pop_ok)
                begin
                    top_reg <= top_plus;
                end
            end
        end
    end

    // Window bytes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
            begin
                regs_reg[i] <= xwrb_pkg::reset_byte(5'(i));
            end
        end
        else if (cmd.exec)
        begin
            if (hit && write_q_reg && is_plain)
            begin
                regs_reg[off] <= wdata_q_reg;
            end
            if (port_adv && rw_sel)
            begin
                regs_reg[xwrb_pkg::OFF_ADDR1_LO] <= adv_addr[7:0];
                regs_reg[xwrb_pkg::OFF_ADDR1_HI] <= adv_addr[15:8];
            end
            if (port_adv && !rw_sel)
            begin
                regs_reg[xwrb_pkg::OFF_ADDR0_LO] <= adv_addr[7:0];
                regs_reg[xwrb_pkg::OFF_ADDR0_HI] <= adv_addr[15:8];
            end
            if (push_ok)
            begin
                regs_reg[xwrb_pkg::OFF_STACK] <= wdata_q_reg;
            end
        end
        else if (cmd.finish)
        begin
            if (load_port_reg && load_sel_reg)
            begin
                regs_reg[xwrb_pkg::OFF_RW1] <= ram_data;
            end
            if (load_port_reg && !load_sel_reg)
            begin
                regs_reg[xwrb_pkg::OFF_RW0] <= ram_data;
            end
            if (load_stack_reg)
            begin
                regs_reg[xwrb_pkg::OFF_STACK] <= (top_reg < DEPTH_T) ? stack_rdata_reg
                                                                     : xwrb_pkg::BYTE_ZERO;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            write_q_reg <= req_type;
            addr_q_reg  <= bus_address;
            wdata_q_reg <= write_data;
        end
        if (cmd.exec)
        begin
            result_reg   <= result_next;
            byp_data_reg <= wdata_q_reg;
        end
        if (cmd.finish)
        begin
            read_data_reg <= result_reg;
        end
    end

    // Extended RAM: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ram_mem[ram_wa] <= ram_wd;
        end
        if (ram_re)
        begin
            ram_rdata_reg <= ram_mem[reload_addr];
        end
    end

    // Byte stack memory.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && push_ok)
        begin
            stack_mem[top_minus[SA_W-1:0]] <= wdata_q_reg;
        end
        if (cmd.exec && pop_show)
        begin
            stack_rdata_reg <= stack_mem[top_plus[SA_W-1:0]];
        end
    end

    assign read_data = read_data_reg;

endmodule

[src/xram_window_register_bus_top.sv]
// ----------------------------------------------------------------------------
// xram_window_register_bus_top
// Bus-side register window with two auto-stepping access ports into a
// 64 KiB extended RAM and a byte stack register.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                    Direction  Handshake
//   request   req_type, bus_address, write_data          in         in_valid/in_ready
//   response  read_data                                  out        out_valid/out_ready
//   config    cfg_wr_data                                in         cfg_wr_en, no wait
//
// Each bus word passes the accept edge, then an execute cycle in which
// the RAM store and the prefetch read share the extended RAM's two
// ports; the finish cycle that loads the prefetch overlaps the next accept.
// After reset the extended RAM is cleared one byte per cycle, with in_ready
// held low; configuration writes are taken during that time.
// A response that is not taken holds the block in its finish cycle, so at
// most one word is in flight and one result waits in the output register.
//
// The window sits at WINDOW_BASE to WINDOW_BASE + 31. Reads of a port's data
// byte return the prefetched byte; writes store it to RAM. Either way the
// port address advances by its signed step and the prefetch reloads. Writes
// to a port's address bytes reload that port's prefetch. The stack byte
// pushes on write (dropped when full) and pops on read (0 when empty). A
// disabled block or an access outside the window reads 0xFF; every write
// returns 0.
// ----------------------------------------------------------------------------
module xram_window_register_bus_top #(
    parameter int STACK_DEPTH = 512,
    parameter int WINDOW_BASE = 928
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [15:0] bus_address,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);

    xwrb_pkg::ctrl_cmd_t  cmd;
    xwrb_pkg::dp_status_t status;

    // Sequencer: clearing pass, accept, execute, finish.
    xwrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Registers, RAM, stack and result path.
    xwrb_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .WINDOW_BASE (WINDOW_BASE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_type    (req_type),
        .bus_address (bus_address),
        .write_data  (write_data),
        .read_data   (read_data)
    );

    // An accepted word is always followed by its execute cycle, during
    // which no further word may be taken.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!in_ready && cmd.exec))
        else $error("second word accepted while one is executing");

    // Retiring a word always presents a result on the next cycle.
    a_finish_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("retired word produced no result");

    // No word is taken while the RAM clearing pass runs.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !in_ready)
        else $error("word accepted during RAM clearing");

    // Execute is only ever entered from a capture on the previous edge.
    a_exec_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> $past(cmd.capture))
        else $error("execute without a captured word");

endmodule
